[rtl/ccae_pkg.sv]
// ccae_pkg: types, constants and helper functions of the char-array literal extractor
// no dependencies; imported by every module of the block
package ccae_pkg;

  localparam int NAME_MAX   = 8;
  localparam int NAME_LEN_W = 4;
  localparam int CHARS_W    = 8 * NAME_MAX;
  localparam int COUNT_W    = 16;
  localparam int CFG_IDX_W  = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_CHARS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_LENGTH = 2'd2;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_DATA      = 2'd0;
  localparam kind_t KIND_FOUND     = 2'd1;
  localparam kind_t KIND_NOT_FOUND = 2'd2;

  typedef enum logic [3:0] {
    PH_SEARCH  = 4'd0,
    PH_SPACES  = 4'd1,
    PH_SCAN    = 4'd2,
    PH_NAME    = 4'd3,
    PH_CLOSE   = 4'd4,
    PH_EQUALS  = 4'd5,
    PH_GAP     = 4'd6,
    PH_SLASH   = 4'd7,
    PH_COMMENT = 4'd8,
    PH_STRING  = 4'd9,
    PH_ESCAPE  = 4'd10,
    PH_HEX1    = 4'd11,
    PH_HEX2    = 4'd12
  } phase_t;

  typedef struct packed {
    logic                  enable;
    logic [CHARS_W-1:0]    chars;
    logic [NAME_LEN_W-1:0] length;
  } cfg_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         data;
    logic [COUNT_W-1:0] count;
    logic               last;
  } result_t;

  // up to two results per item, always packed from slot 0
  typedef struct packed {
    logic    valid0;
    logic    valid1;
    result_t r0;
    result_t r1;
  } result_pair_t;

  typedef struct packed {
    logic       done;
    logic [2:0] pos;
  } kw_step_t;

  function automatic logic is_ws(input logic [7:0] b);
    is_ws = b inside {8'h20, 8'h0D, 8'h0A, 8'h09};
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [7:0] t;
    t = 8'h00;
    if (b inside {[8'h30:8'h39]}) t = b - 8'h30;
    else if (b inside {[8'h41:8'h46]}) t = b - 8'h37;
    else if (b inside {[8'h61:8'h66]}) t = b - 8'h57;
    hex_value = t[3:0];
  endfunction

  // characters of "char "
  function automatic logic [7:0] kw_char(input logic [2:0] pos);
    case (pos)
      3'd0:    kw_char = 8'h63;
      3'd1:    kw_char = 8'h68;
      3'd2:    kw_char = 8'h61;
      3'd3:    kw_char = 8'h72;
      default: kw_char = 8'h20;
    endcase
  endfunction

  function automatic kw_step_t kw_step(input logic [2:0] pos, input logic [7:0] b);
    logic [2:0] p;
    kw_step_t   s;
    p = (pos > 3'd4) ? 3'd0 : pos;
    s.done = 1'b0;
    if (b == kw_char(p)) begin
      if (p == 3'd4) begin
        s.done = 1'b1;
        s.pos  = 3'd0;
      end else begin
        s.pos = p + 3'd1;
      end
    end else begin
      s.pos = (b == 8'h63) ? 3'd1 : 3'd0;
    end
    kw_step = s;
  endfunction

endpackage

[rtl/ccae_parser.sv]
// ccae_parser: parse state and one-byte step of the extractor
// depends on ccae_pkg
module ccae_parser
  import ccae_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step_en,
  input  logic [7:0]   in_byte,
  input  logic         end_of_text,
  input  cfg_t         cfg,
  output result_pair_t results
);

  phase_t                phase_r, phase_nxt;
  logic [2:0]            kw_r, kw_nxt;
  logic [NAME_LEN_W-1:0] np_r, np_nxt;
  logic                  cs_r, cs_nxt;
  logic [3:0]            hn_r, hn_nxt;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic                  fin_r, fin_nxt;

  logic                  active;
  logic                  do_search, emit, found, done;
  logic [7:0]            data;
  logic [NAME_LEN_W-1:0] name_len, pos_cur;
  logic [7:0]            name_ch;
  kw_step_t              kws;

  assign active   = step_en && !fin_r;
  assign name_len = (cfg.length > NAME_LEN_W'(NAME_MAX)) ? NAME_LEN_W'(NAME_MAX) : cfg.length;
  assign pos_cur  = (phase_r == PH_SPACES) ? '0 : np_r;
  assign name_ch  = cfg.chars[8*pos_cur[2:0] +: 8];
  assign kws      = kw_step(kw_r, in_byte);

  always_comb begin
    phase_nxt = phase_r;
    kw_nxt    = kw_r;
    np_nxt    = np_r;
    cs_nxt    = cs_r;
    hn_nxt    = hn_r;
    do_search = 1'b0;
    emit      = 1'b0;
    found     = 1'b0;
    data      = 8'h00;
    case (phase_r)
      PH_SEARCH: do_search = 1'b1;
      PH_SPACES, PH_NAME: begin
        if (phase_r == PH_SPACES && in_byte == 8'h20) begin
          phase_nxt = phase_r;
        end else if (phase_r == PH_SPACES && !cfg.enable) begin
          phase_nxt = (in_byte == 8'h5B) ? PH_CLOSE : PH_SCAN;
        end else begin
          np_nxt = pos_cur;
          if (pos_cur >= name_len) begin
            if (in_byte == 8'h5B) phase_nxt = PH_CLOSE;
            else do_search = 1'b1;
          end else if (in_byte == name_ch) begin
            np_nxt    = pos_cur + 1'b1;
            phase_nxt = PH_NAME;
          end else begin
            do_search = 1'b1;
          end
        end
      end
      PH_SCAN: if (in_byte == 8'h5B) phase_nxt = PH_CLOSE;
      PH_CLOSE: begin
        if (in_byte == 8'h5D) phase_nxt = PH_EQUALS;
        else do_search = 1'b1;
      end
      PH_EQUALS: begin
        if (!is_ws(in_byte)) begin
          if (in_byte == 8'h3D) phase_nxt = PH_GAP;
          else do_search = 1'b1;
        end
      end
      PH_GAP: begin
        if (!is_ws(in_byte)) begin
          if (in_byte == 8'h2F) phase_nxt = PH_SLASH;
          else if (in_byte == 8'h22) phase_nxt = PH_STRING;
          else found = 1'b1;
        end
      end
      PH_SLASH: begin
        if (in_byte == 8'h2A) begin
          phase_nxt = PH_COMMENT;
          cs_nxt    = 1'b0;
        end else begin
          found = 1'b1;
        end
      end
      PH_COMMENT: begin
        if (cs_r && in_byte == 8'h2F) begin
          phase_nxt = PH_GAP;
          cs_nxt    = 1'b0;
        end else begin
          cs_nxt = (in_byte == 8'h2A);
        end
      end
      PH_STRING: begin
        if (in_byte == 8'h22) phase_nxt = PH_GAP;
        else if (in_byte == 8'h5C) phase_nxt = PH_ESCAPE;
        else begin
          emit = 1'b1;
          data = in_byte;
        end
      end
      PH_ESCAPE: phase_nxt = (in_byte == 8'h78) ? PH_HEX1 : PH_STRING;
      PH_HEX1: begin
        hn_nxt    = hex_value(in_byte);
        phase_nxt = PH_HEX2;
      end
      PH_HEX2: begin
        emit      = 1'b1;
        data      = {hn_r, hex_value(in_byte)};
        phase_nxt = PH_STRING;
      end
      default: do_search = 1'b1;
    endcase
    // keyword search restarts on the current byte
    if (do_search) begin
      kw_nxt    = kws.pos;
      phase_nxt = kws.done ? PH_SPACES : PH_SEARCH;
    end
  end

  assign done    = found || end_of_text;
  assign cnt_nxt = (emit && cnt_r != '1) ? cnt_r + 1'b1 : cnt_r;
  assign fin_nxt = fin_r || (active && done);

  always_comb begin
    results.valid0   = active && (emit || done);
    results.valid1   = active && emit && done;
    results.r0.kind  = emit ? KIND_DATA : (found ? KIND_FOUND : KIND_NOT_FOUND);
    results.r0.data  = emit ? data : 8'h00;
    results.r0.count = cnt_nxt;
    results.r0.last  = !(emit && done);
    results.r1.kind  = found ? KIND_FOUND : KIND_NOT_FOUND;
    results.r1.data  = 8'h00;
    results.r1.count = cnt_nxt;
    results.r1.last  = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      kw_r    <= '0;
      np_r    <= '0;
      cs_r    <= 1'b0;
      hn_r    <= '0;
      cnt_r   <= '0;
      fin_r   <= 1'b0;
    end else begin
      fin_r <= fin_nxt;
      if (active) begin
        phase_r <= phase_nxt;
        kw_r    <= kw_nxt;
        np_r    <= np_nxt;
        cs_r    <= cs_nxt;
        hn_r    <= hn_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

endmodule

[rtl/ccae_out_queue.sv]
// ccae_out_queue: four-entry result queue, up to two pushes and one pop per cycle
// depends on ccae_pkg
module ccae_out_queue
  import ccae_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  result_pair_t push,
  input  logic         pop,
  output logic         not_empty,
  output logic         room,
  output result_t      head
);

  result_t    entries [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic [1:0] n_push;
  logic       do_pop;

  assign n_push     = {1'b0, push.valid0} + {1'b0, push.valid1};
  assign do_pop     = pop && not_empty;
  assign not_empty  = (count_r != 3'd0);
  assign room       = (count_r <= 3'd2);
  assign head       = entries[rd_ptr_r];
  assign wr_ptr_nxt = wr_ptr_r + n_push;
  assign rd_ptr_nxt = rd_ptr_r + {1'b0, do_pop};
  assign count_nxt  = count_r + {1'b0, n_push} - {2'b00, do_pop};

  always_ff @(posedge clk) begin
    if (push.valid0) entries[wr_ptr_r] <= push.r0;
    if (push.valid1) entries[wr_ptr_r + 2'd1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[rtl/c_char_array_literal_extractor.sv]
// c_char_array_literal_extractor: top level of the char-array literal extractor
// depends on ccae_pkg, ccae_parser, ccae_out_queue
//
// channel  direction  tdata                            tuser        tlast
// in_      slave      [7:0] in_byte                    -            end_of_text
// out_     master     [7:0] data_byte [23:8] byte_count [1:0] kind  last_of_run
// cfg_     write      cfg_wdata, index in cfg_index    -            -
//
// one item per cycle while the queue has room: an item is held in the input
// register and parsed there in a single step; results land in a four-entry queue
// a text's final item may give two results, drained one per cycle on out_tready
// the input register only advances while the queue has room for two results,
// so a stalled output side backs up into in_tready once three results are queued
// synchronous active-low reset clears the parse state, queue, input valid and cfg registers
module c_char_array_literal_extractor
  import ccae_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] in_byte
  input  logic                 in_tlast,   // end_of_text
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // [7:0] data_byte, [23:8] byte_count
  output logic [1:0]           out_tuser,  // [1:0] result_kind
  output logic                 out_tlast,  // last_of_run
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CHARS_W-1:0]   cfg_wdata
);

  // input register
  logic         in_valid_r, in_valid_nxt;
  logic [7:0]   in_byte_r;
  logic         in_last_r;
  logic         in_take, advance, room;

  // configuration registers
  cfg_t         cfg_r;

  result_pair_t results;
  result_t      head;

  // the queue needs room for the worst case of two results
  assign advance      = in_valid_r && room;
  assign in_tready    = !in_valid_r || advance;
  assign in_take      = in_tvalid && in_tready;
  assign in_valid_nxt = in_take || (in_valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // configuration writes, indexes beyond the list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NAME_ENABLE: cfg_r.enable <= cfg_wdata[0];
        CFG_NAME_CHARS:  cfg_r.chars  <= cfg_wdata;
        CFG_NAME_LENGTH: cfg_r.length <= cfg_wdata[NAME_LEN_W-1:0];
        default:         cfg_r        <= cfg_r;
      endcase
    end
  end

  ccae_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (advance),
    .in_byte     (in_byte_r),
    .end_of_text (in_last_r),
    .cfg         (cfg_r),
    .results     (results)
  );

  ccae_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (results),
    .pop       (out_tready),
    .not_empty (out_tvalid),
    .room      (room),
    .head      (head)
  );

  assign out_tdata = {head.count, head.data};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule
